@@ hdl/cigar_string_parser_unit_macros.svh @@
// Assertion macros for the CIGAR string parser.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CIGAR_STRING_PARSER_UNIT_MACROS_SVH
`define CIGAR_STRING_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csp assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define CSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csp assertion failed: next-cycle check");

`endif

@@ hdl/csp_pkg.sv @@
// Shared types, codes and helpers for the CIGAR string parser.
// No dependencies; used by csp_parse, csp_rq and the top level.
`timescale 1ns / 1ps

package csp_pkg;

	localparam int SPAN_BITS_DEF = 32;
	localparam int COUNT_W = 28;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Result queue geometry.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW = 2;

	// ASCII characters of interest.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_H = 8'h48;

	// Operator codes on the result stream.
	localparam logic [2:0] OP_M = 3'd0;
	localparam logic [2:0] OP_I = 3'd1;
	localparam logic [2:0] OP_D = 3'd2;
	localparam logic [2:0] OP_S = 3'd4;
	localparam logic [2:0] OP_H = 3'd5;

	localparam logic KIND_ELEM = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_DIGIT = 2'd1,
		ERR_OP    = 2'd2,
		ERR_END   = 2'd3
	} err_t;

	typedef struct packed {
		logic               kind;
		logic [2:0]         op_code;
		logic [COUNT_W-1:0] op_length;
		logic [31:0]        span_length;
		err_t               error_code;
		logic               run_end;
	} result_t;

	// Up to two results written into the queue per accepted byte.
	typedef struct packed {
		logic [1:0] n;
		result_t    a;
		result_t    b;
	} rq_push_t;

	// Bit 3 flags a known operator, bits 2:0 carry its code.
	function automatic logic [3:0] op_lookup(input logic [7:0] ch);
		logic [3:0] r;
		unique case (ch)
			CH_M:    r = {1'b1, OP_M};
			CH_I:    r = {1'b1, OP_I};
			CH_D:    r = {1'b1, OP_D};
			CH_S:    r = {1'b1, OP_S};
			CH_H:    r = {1'b1, OP_H};
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/cigar_string_parser_unit.sv @@
// CIGAR string parser: one text byte per beat in, element and summary records out.
// The records of a byte are written into the result queue as it is accepted and offered from its head.
// Throughput: one byte per cycle; a final byte that closes an element makes two
// records, but the byte before it makes none, so input stalls only while output stalls.
// Reset (arst_n low, asynchronous) clears the parse state and empties the result queue.
// Depends on csp_pkg, csp_parse, csp_rq and cigar_string_parser_unit_macros.svh.
`timescale 1ns / 1ps
`include "cigar_string_parser_unit_macros.svh"

module cigar_string_parser_unit
	import csp_pkg::*;
#(
	parameter int SPAN_BITS = SPAN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input channel: one character per beat.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          text_byte,
	input  logic                final_byte,
	// Output channel: one record per beat.
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [2:0]          op_code,
	output logic [COUNT_W-1:0]  op_length,
	output logic [31:0]         span_length,
	output logic [1:0]          error_code,
	output logic                run_end
);

	logic           in_fire;
	logic           out_fire;
	rq_push_t       push;
	result_t        head;
	logic [RQ_AW:0] level;

	// A byte can produce two records, so input is held off unless the queue
	// has room for two. The decision uses only registered occupancy, so it
	// does not depend on the incoming valid.
	assign in_stall = (level > (RQ_AW + 1)'(RQ_DEPTH - 2));
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;

	// The parser classifies the byte, updates the element count, the span and
	// the sticky error, and hands zero, one or two records to the queue in the
	// same cycle. The queue registers them, so the output is fully registered.
	csp_parse #(
		.SPAN_BITS (SPAN_BITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.push       (push)
	);

	csp_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_fire),
		.not_empty (out_valid),
		.level     (level),
		.head      (head)
	);

	assign result_kind = head.kind;
	assign op_code     = head.op_code;
	assign op_length   = head.op_length;
	assign span_length = head.span_length;
	assign error_code  = head.error_code;
	assign run_end     = head.run_end;

	// The queue never holds more records than it has entries.
	`CSP_ASSERT_NOW(a_rq_bound, 1'b1, level <= (RQ_AW + 1)'(RQ_DEPTH))
	// A summary record is always the last record of its byte.
	`CSP_ASSERT_NOW(a_summary_last, out_valid && result_kind == KIND_SUMMARY, run_end)
	// Element records never carry an error code.
	`CSP_ASSERT_NOW(a_elem_no_err, out_valid && result_kind == KIND_ELEM, error_code == ERR_NONE)
	// A final byte always leaves a record waiting in the next cycle.
	`CSP_ASSERT_NEXT(a_final_out, in_fire && final_byte, out_valid)

endmodule

@@ hdl/csp_parse.sv @@
// Byte classifier and parse state of the CIGAR string parser.
// Depends on csp_pkg; feeds result records to csp_rq.
`timescale 1ns / 1ps

module csp_parse
	import csp_pkg::*;
#(
	parameter int SPAN_BITS = SPAN_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	output rq_push_t   push
);

	localparam int SUM_W = ((SPAN_BITS > COUNT_W) ? SPAN_BITS : COUNT_W) + 1;
	localparam int EXT_W = (SPAN_BITS > 32) ? SPAN_BITS : 32;

	logic [COUNT_W-1:0]   count_q, count_n;
	logic                 digits_q, digits_n;
	logic [SPAN_BITS-1:0] span_q, span_n;
	err_t                 err_q, err_n;

	logic                 is_digit;
	logic [3:0]           op_info;
	logic [31:0]          prod;
	logic [COUNT_W-1:0]   count_sat;
	logic [SUM_W-1:0]     span_sum;
	logic [SPAN_BITS-1:0] span_sat;
	logic [EXT_W-1:0]     span_ext;
	logic                 elem_fire;
	result_t              elem_rec, sum_rec;

	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign op_info  = op_lookup(text_byte);

	// count * 10 + digit; the count is below 2^28, so 32 bits hold it.
	assign prod = {1'b0, count_q, 3'b000} + {3'b000, count_q, 1'b0}
		+ 32'(text_byte - CH_ZERO);
	assign count_sat = (prod > 32'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_W-1:0];

	assign span_sum = SUM_W'(span_q) + SUM_W'(count_q);
	assign span_sat = (span_sum[SUM_W-1:SPAN_BITS] != '0) ? '1 : span_sum[SPAN_BITS-1:0];

	always_comb begin
		count_n   = count_q;
		digits_n  = digits_q;
		span_n    = span_q;
		err_n     = err_q;
		elem_fire = 1'b0;
		if (err_q == ERR_NONE) begin
			if (is_digit) begin
				count_n  = count_sat;
				digits_n = 1'b1;
				if (final_byte) begin
					err_n = ERR_END;
				end
			end else if (!digits_q) begin
				err_n = ERR_DIGIT;
			end else if (!op_info[3]) begin
				err_n = ERR_OP;
			end else begin
				if (op_info[2:0] == OP_M || op_info[2:0] == OP_D) begin
					span_n = span_sat;
				end
				elem_fire = 1'b1;
				count_n   = '0;
				digits_n  = 1'b0;
			end
		end
	end

	assign span_ext = EXT_W'(span_n);

	always_comb begin
		elem_rec.kind        = KIND_ELEM;
		elem_rec.op_code     = op_info[2:0];
		elem_rec.op_length   = count_q;
		elem_rec.span_length = span_ext[31:0];
		elem_rec.error_code  = ERR_NONE;
		elem_rec.run_end     = !final_byte;

		sum_rec.kind        = KIND_SUMMARY;
		sum_rec.op_code     = OP_M;
		sum_rec.op_length   = '0;
		sum_rec.span_length = span_ext[31:0];
		sum_rec.error_code  = err_n;
		sum_rec.run_end     = 1'b1;

		push.a = elem_fire ? elem_rec : sum_rec;
		push.b = sum_rec;
		if (!fire) begin
			push.n = 2'd0;
		end else begin
			push.n = 2'({1'b0, elem_fire} + {1'b0, final_byte});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			digits_q <= 1'b0;
			span_q   <= '0;
			err_q    <= ERR_NONE;
		end else if (fire) begin
			if (final_byte) begin
				count_q  <= '0;
				digits_q <= 1'b0;
				span_q   <= '0;
				err_q    <= ERR_NONE;
			end else begin
				count_q  <= count_n;
				digits_q <= digits_n;
				span_q   <= span_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

@@ hdl/csp_rq.sv @@
// Small result queue: takes up to two records per cycle, gives one.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_rq
	import csp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  rq_push_t       push,
	input  logic           pop,
	output logic           not_empty,
	output logic [RQ_AW:0] level,
	output result_t        head
);

	result_t            mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   wr_q, rd_q;
	logic [RQ_AW:0]     count_q;

	assign not_empty = (count_q != '0);
	assign level     = count_q;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + RQ_AW'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RQ_AW'(push.n);
			rd_q    <= rd_q + RQ_AW'(pop);
			count_q <= count_q + (RQ_AW + 1)'(push.n) - (RQ_AW + 1)'(pop);
		end
	end

endmodule
